// ===== hdl/smud_pkg.sv =====
`default_nettype none
package smud_pkg;

  localparam int unsigned RawBytesDefault = 65536;
  localparam int unsigned MaxDimDefault   = 4096;

  localparam int unsigned ModeW   = 1;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned DimW    = 13;
  localparam int unsigned CountW  = 17;
  localparam int unsigned BitsW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT       = 3'd0,
    CFG_ROW_COUNT    = 3'd1,
    CFG_COLUMN_COUNT = 3'd2,
    CFG_PERMUTE      = 3'd3,
    CFG_RAW_COUNT    = 3'd4
  } cfg_index_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SHAPE = 3'd1,
    ST_TOO_SMALL = 3'd2,
    ST_BEYOND    = 3'd3,
    ST_OUTSIDE   = 3'd4
  } status_t;

  localparam logic [ModeW-1:0] MODE_LOAD  = 1'b0;
  localparam logic [ModeW-1:0] MODE_FETCH = 1'b1;

  // Channel bit permutation: bit 1 -> bit 3, bit 2 -> bit 1, bit 3 -> bit 2.
  function automatic logic [CoordW-1:0] permute_channel(input logic [CoordW-1:0] c);
    logic [CoordW-1:0] p;
    p    = c;
    p[3] = c[1];
    p[1] = c[2];
    p[2] = c[3];
    return p;
  endfunction

  // float32 bits of m * 2^(-shift) for nonzero m below 2^10.
  function automatic logic [30:0] small_value_bits(input logic [9:0] m,
                                                   input logic [7:0] shift);
    logic [3:0]  p;
    logic [22:0] frac;
    logic [9:0]  rest;
    p = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    rest = m & ~(10'd1 << p);
    frac = 23'(rest) << (5'd23 - 5'(p));
    return {8'(8'd127 - shift + 8'(p)), frac};
  endfunction

  function automatic logic [BitsW-1:0] decode_e4m3(input logic [7:0] b);
    logic [BitsW-1:0] sign;
    logic [3:0] e;
    logic [2:0] m;
    sign = {b[7], 31'd0};
    e    = b[6:3];
    m    = b[2:0];
    if (e == 4'd15 && m == 3'd7) return sign | 32'h7FC0_0000;
    if (e == 4'd0) begin
      if (m == 3'd0) return sign;
      return sign | {1'b0, small_value_bits(10'(m), 8'd9)};
    end
    return sign | {1'b0, 8'(e) + 8'd120, m, 20'd0};
  endfunction

  function automatic logic [BitsW-1:0] decode_half(input logic [15:0] h);
    logic [BitsW-1:0] sign;
    logic [4:0] e;
    logic [9:0] m;
    sign = {h[15], 31'd0};
    e    = h[14:10];
    m    = h[9:0];
    if (e == 5'd0) begin
      if (m == 10'd0) return sign;
      return sign | {1'b0, small_value_bits(m, 8'd24)};
    end
    if (e == 5'd31) return sign | ((m != 10'd0) ? 32'h7FC0_0000 : 32'h7F80_0000);
    return sign | {1'b0, 8'(e) + 8'd112, m, 13'd0};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/smud_if.sv =====
`default_nettype none
interface smud_in_if;
  import smud_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [15:0]       byte_address;
  logic [ByteW-1:0]  byte_value;
  logic [CoordW-1:0] row;
  logic [CoordW-1:0] column;
  modport source (output valid, mode, byte_address, byte_value, row, column, input ready);
  modport sink   (input valid, mode, byte_address, byte_value, row, column, output ready);
endinterface

interface smud_out_if;
  import smud_pkg::*;
  logic               valid;
  logic               ready;
  logic [BitsW-1:0]   value_bits;
  logic [StatusW-1:0] status;
  modport source (output valid, value_bits, status, input ready);
  modport sink   (input valid, value_bits, status, output ready);
endinterface

interface smud_cfg_if;
  import smud_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/swizzled_matrix_unpack_decode_unit.sv =====
`default_nettype none
// Channel  Direction  Payload
// cfg      in         index (register number), data
// in_ch    in         mode, byte_address, byte_value, row, column
// out_ch   out        value_bits, status (one item per fetch, none per load)
//
// One item enters per cycle while input ready is high, loads and fetches alike. A fetch
// has its checks, index and buffer read done at the edge that accepts it, is
// decoded in stage 2 and then written into the output queue, from which its
// result can be taken.
// The output queue holds four results; input ready is low while queued results
// plus fetches in the two stages reach four, which keeps one item per cycle
// when the consumer takes every result and never depends on output ready.
// Reset clears the stage valid bits, empties the queue and sets the configuration
// to its defaults; the buffer needs no clear.
module swizzled_matrix_unpack_decode_unit #(
  parameter int unsigned RAW_BYTES = smud_pkg::RawBytesDefault,
  parameter int unsigned MAX_DIM   = smud_pkg::MaxDimDefault
) (
  input wire logic clk,
  input wire logic rst,
  smud_cfg_if.sink   cfg,
  smud_in_if.sink    in_ch,
  smud_out_if.source out_ch
);
  import smud_pkg::*;

  localparam int unsigned AddrW = $clog2(RAW_BYTES);
  localparam int unsigned HalfW = AddrW - 1;
  localparam int unsigned HalfDepth = RAW_BYTES / 2;
  localparam int unsigned IdxW = 32;

  // Configuration registers.
  logic              format;
  logic [DimW-1:0]   row_count;
  logic [DimW-1:0]   column_count;
  logic              permute_enable;
  logic [CountW-1:0] raw_byte_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      format         <= 1'b0;
      row_count      <= DimW'(16);
      column_count   <= DimW'(32);
      permute_enable <= 1'b0;
      raw_byte_count <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FORMAT:       format         <= cfg.data[0];
        CFG_ROW_COUNT:    row_count      <= cfg.data[DimW-1:0];
        CFG_COLUMN_COUNT: column_count   <= cfg.data[DimW-1:0];
        CFG_PERMUTE:      permute_enable <= cfg.data[0];
        CFG_RAW_COUNT:    raw_byte_count <= cfg.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Checks that depend only on configuration; they take effect for a fetch
  // in the very cycle after a register write.
  logic [IdxW-1:0] eff_size;
  logic [IdxW-1:0] need;
  logic            shape_bad;
  logic            too_small;

  always_comb begin
    eff_size  = (32'(raw_byte_count) > 32'(RAW_BYTES)) ? 32'(RAW_BYTES) :
                                                         32'(raw_byte_count);
    need      = (32'(row_count) * 32'(column_count)) << format;
    shape_bad = (row_count == '0) || (column_count == '0) || (row_count[3:0] != '0) ||
                (column_count[3:0] != '0) || (32'(row_count) > 32'(MAX_DIM)) ||
                (32'(column_count) > 32'(MAX_DIM)) || (!format && column_count[4]);
    too_small = eff_size < need;
  end

  // Stall control: the queue holds four results; stage valids count in flight.
  logic s1_valid, s2_valid;
  logic [2:0] skid_count;
  logic       advance;
  logic [1:0] inflight;

  assign inflight    = 2'(s1_valid) + 2'(s2_valid);
  assign advance     = 1'b1;
  assign in_ch.ready = (3'(skid_count) + 3'(inflight)) < 3'd4;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Stage 1: status checks, index calculation, buffer access.
  logic [CoordW-1:0] r, c;
  logic [IdxW-1:0]   idx, lo_addr;
  logic              coord_out;
  status_t           st1;

  always_comb begin
    logic [IdxW-1:0] kb, nb, rr, cc, d2, d3, d4, d5, d6;
    r  = permute_enable ? permute_channel(in_ch.row) : in_ch.row;
    c  = permute_enable ? permute_channel(in_ch.column) : in_ch.column;
    nb = 32'(r[CoordW-1:4]);
    rr = 32'(r[3:0]);
    d4 = rr >> 3;
    d2 = rr & 32'd7;
    kb = format ? 32'(c[CoordW-1:4]) : 32'(c[CoordW-1:5]);
    cc = format ? 32'(c[3:0]) : 32'(c[4:0]);
    d5 = cc >> 3;
    d3 = (cc & 32'd7) >> 1;
    d6 = cc & 32'd1;
    // kb*(rows/16) is at most 256*256: a narrow multiply.
    if (format)
      idx = ((32'(kb[15:0]) * 32'(row_count[DimW-1:4])) << 8) + (nb << 8) + (d2 << 5) +
            (d3 << 3) + (d4 << 2) + (d5 << 1) + d6;
    else
      idx = ((32'(kb[15:0]) * 32'(row_count[DimW-1:4])) << 9) + (nb << 9) + (d2 << 6) +
            (d3 << 4) + (d4 << 3) + (d5 << 1) + d6;
    lo_addr   = format ? (idx << 1) : idx;
    coord_out = (13'(in_ch.row) >= row_count) || (13'(in_ch.column) >= column_count);
    if (shape_bad)      st1 = ST_BAD_SHAPE;
    else if (too_small) st1 = ST_TOO_SMALL;
    else if (coord_out) st1 = ST_OUTSIDE;
    else if ((format ? lo_addr + 32'd1 : lo_addr) >= eff_size) st1 = ST_BEYOND;
    else st1 = ST_OK;
  end

  // Two banks: even and odd byte addresses, so an FP16 pair is one read.
  logic [ByteW-1:0] bank_even [HalfDepth];
  logic [ByteW-1:0] bank_odd  [HalfDepth];
  logic [ByteW-1:0] rd_even, rd_odd;
  logic [HalfW-1:0] wr_addr, rd_addr;
  logic             wr_even, wr_odd;

  assign wr_addr = HalfW'(in_ch.byte_address >> 1);
  assign wr_even = in_fire && in_ch.mode == MODE_LOAD &&
                   32'(in_ch.byte_address) < 32'(RAW_BYTES) && !in_ch.byte_address[0];
  assign wr_odd  = in_fire && in_ch.mode == MODE_LOAD &&
                   32'(in_ch.byte_address) < 32'(RAW_BYTES) && in_ch.byte_address[0];
  assign rd_addr = lo_addr[AddrW-1:1];

  always_ff @(posedge clk) begin
    if (wr_even) bank_even[wr_addr] <= in_ch.byte_value;
    rd_even <= bank_even[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_odd) bank_odd[wr_addr] <= in_ch.byte_value;
    rd_odd <= bank_odd[rd_addr];
  end

  // A load in the cycle before a fetch to the same byte has already been
  // written when the fetch reads, since memory writes precede in time.
  // Same-cycle cannot occur: one item per cycle.

  status_t s1_status;
  logic    s1_odd, s1_fmt;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_fire && in_ch.mode == MODE_FETCH;
    s1_status <= st1;
    s1_odd    <= lo_addr[0];
    s1_fmt    <= format;
  end

  // Stage 2: decode.
  logic [BitsW-1:0] s2_bits;
  status_t          s2_status;
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_status <= s1_status;
    if (s1_status != ST_OK) s2_bits <= '0;
    else if (s1_fmt)        s2_bits <= decode_half({rd_odd, rd_even});
    else                    s2_bits <= decode_e4m3(s1_odd ? rd_odd : rd_even);
  end

  // Output queue, four entries.
  logic [BitsW+StatusW-1:0] q [4];
  logic [1:0]               q_head;
  logic                     out_fire;
  assign out_fire      = out_ch.valid && out_ch.ready;
  assign out_ch.valid  = skid_count != 3'd0;
  assign out_ch.value_bits = q[q_head][BitsW+StatusW-1:StatusW];
  assign out_ch.status     = q[q_head][StatusW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_count <= '0;
      q_head     <= '0;
    end else begin
      if (s2_valid && advance) q[2'(q_head + skid_count[1:0])] <= {s2_bits, s2_status};
      if (out_fire) q_head <= q_head + 2'd1;
      skid_count <= skid_count + 3'(s2_valid) - 3'(out_fire);
    end
  end

endmodule
`default_nettype wire
